// ----- src/sha256_byte_stream_hasher_assert.svh -----
// ----------------------------------------------------------------------------
// SHA-256 hasher assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication.
`define SHABS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("shabs assertion failed");

// Next-cycle implication.
`define SHABS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("shabs assertion failed");

`endif

// ----- src/shabs_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash value, round functions and shared types.
// ----------------------------------------------------------------------------
package shabs_pkg;

    localparam int WORD_W   = 32;
    localparam int BLK_WORDS = 16;
    localparam int ROUNDS   = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [7:0][WORD_W-1:0] chain_t;
    typedef logic [BLK_WORDS*WORD_W-1:0] block_t;

    typedef struct packed {
        logic start;   // block register holds 16 complete words
        logic reinit;  // load initial hash value
    } comp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;    // one-cycle pulse, chain words updated
    } comp_stat_t;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam chain_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t ror(input word_t v, input int k);
        ror = (v >> k) | (v << (WORD_W - k));
    endfunction

    function automatic word_t big_sigma0(input word_t v);
        big_sigma0 = ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t v);
        big_sigma1 = ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t v);
        small_sigma0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t v);
        small_sigma1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

endpackage

// ----- src/sha256_byte_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Collects message bytes, pads, drives the compression unit, emits digest.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_*): s_tdata is the message byte, s_tuser says the byte is
//   present, s_tlast ends the message. A beat with s_tuser low and s_tlast
//   high finishes the message as it stands (empty message allowed).
//   Output beats (m_*): eight digest words, word 0 (most significant) first;
//   m_tuser is the word index and m_tlast marks word 7.
//   Throughput: one byte per cycle while a block fills; the 64th byte of a
//   block starts the compression unit. s_tready then stays low through the
//   start cycle, 64 rounds in one shared round unit, the chaining add and the
//   done cycle.
//   End of message: one pad byte per cycle up to the block end, then one or
//   two compressions, then eight output beats.
//   A stalled receiver holds the block in its output state; no input is taken
//   until the last digest beat is accepted, after which the chain words go
//   back to the initial hash value and the bit count to zero.
//   Reset: synchronous, active-low aresetn; state returns to the initial
//   hash value with an empty block, ready for input.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import shabs_pkg::*;

    `include "sha256_byte_stream_hasher_assert.svh"

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;   // length field starts here
    localparam logic [7:0] PAD_MARK  = 8'h80;

    typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_OUT} state_t;
    typedef enum logic [1:0] {PK_MARK, PK_ZERO, PK_LEN} pad_kind_t;

    state_t     state_reg;
    pad_kind_t  kind_reg;
    logic [5:0] fill_reg;
    logic [63:0] bitlen_reg;
    logic [63:0] len_sh_reg;    // latched length, top byte goes next
    logic [2:0] len_idx_reg;
    logic       len_done_reg;
    logic       pad_active_reg;
    logic       start_reg;
    logic       reinit_reg;
    logic [2:0] out_idx_reg;
    block_t     blk_reg;

    comp_ctrl_t ctl;
    comp_stat_t stat;
    chain_t     hash;

    logic       s_accept;
    logic       m_accept;
    logic       put_en;
    logic [7:0] put_byte;
    logic       len_byte;     // this pad byte is a length byte

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    always_comb begin
        len_byte = 1'b0;
        put_byte = s_tdata;
        put_en   = 1'b0;
        unique case (state_reg)
            S_IDLE: put_en = s_accept && s_tuser;
            S_PAD: begin
                put_en = 1'b1;
                unique case (kind_reg)
                    PK_MARK: put_byte = PAD_MARK;
                    PK_ZERO: begin
                        len_byte = (fill_reg == FILL_LEN);
                        put_byte = len_byte ? len_sh_reg[63:56] : 8'h00;
                    end
                    PK_LEN: begin
                        len_byte = 1'b1;
                        put_byte = len_sh_reg[63:56];
                    end
                    default: put_byte = 8'h00;
                endcase
            end
            S_COMP, S_OUT: put_en = 1'b0;
            default: put_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            kind_reg       <= PK_MARK;
            fill_reg       <= '0;
            bitlen_reg     <= '0;
            len_idx_reg    <= '0;
            len_done_reg   <= 1'b0;
            pad_active_reg <= 1'b0;
            start_reg      <= 1'b0;
            reinit_reg     <= 1'b0;
            out_idx_reg    <= '0;
        end else begin
            start_reg  <= 1'b0;
            reinit_reg <= 1'b0;

            if (put_en) begin
                blk_reg  <= {blk_reg[$bits(block_t)-9:0], put_byte};
                fill_reg <= fill_reg + 6'd1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser) begin
                            bitlen_reg <= bitlen_reg + 64'd8;
                        end
                        if (s_tlast) begin
                            pad_active_reg <= 1'b1;
                            kind_reg       <= PK_MARK;
                            len_idx_reg    <= '0;
                            len_done_reg   <= 1'b0;
                            len_sh_reg     <= bitlen_reg + (s_tuser ? 64'd8 : 64'd0);
                        end
                        if (s_tuser && (fill_reg == FILL_LAST)) begin
                            start_reg <= 1'b1;
                            state_reg <= S_COMP;
                        end else if (s_tlast) begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (kind_reg == PK_MARK) begin
                        kind_reg <= PK_ZERO;
                    end
                    if (len_byte) begin
                        kind_reg    <= PK_LEN;
                        len_sh_reg  <= {len_sh_reg[55:0], 8'h00};
                        len_idx_reg <= len_idx_reg + 3'd1;
                        if (len_idx_reg == 3'd7) begin
                            len_done_reg <= 1'b1;
                        end
                    end
                    if (fill_reg == FILL_LAST) begin
                        start_reg <= 1'b1;
                        state_reg <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (stat.done) begin
                        out_idx_reg <= '0;
                        if (!pad_active_reg) begin
                            state_reg <= S_IDLE;
                        end else if (len_done_reg) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (m_accept) begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7) begin
                            reinit_reg     <= 1'b1;
                            bitlen_reg     <= '0;
                            pad_active_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ctl.start  = start_reg;
    assign ctl.reinit = reinit_reg;

    shabs_compress u_compress (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .block   (blk_reg),
        .stat    (stat),
        .hash    (hash)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = hash[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == 3'd7);

    `SHABS_ASSERT_IMPL(a_out_blocks_in, m_tvalid, !s_tready)
    `SHABS_ASSERT_NEXT(a_eom_stalls_in, s_accept && s_tlast, !s_tready)
    `SHABS_ASSERT_NEXT(a_end_clears, m_accept && m_tlast,
                       (bitlen_reg == 64'd0) && (fill_reg == 6'd0) && reinit_reg)
    `SHABS_ASSERT_IMPL(a_idle_unit_free, state_reg == S_IDLE, !stat.busy)

endmodule

// ----- src/shabs_compress.sv -----
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// One shared round per cycle, rolling 16-word schedule window,
// then the chaining add. Holds the eight chaining words.
// ----------------------------------------------------------------------------
module shabs_compress (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  shabs_pkg::comp_ctrl_t ctl,
    input  shabs_pkg::block_t     block,
    output shabs_pkg::comp_stat_t stat,
    output shabs_pkg::chain_t     hash
);
    import shabs_pkg::*;

    `include "sha256_byte_stream_hasher_assert.svh"

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

    cstate_t st_reg;
    logic [5:0] rnd_reg;
    logic done_reg;
    chain_t h_reg;
    chain_t v_reg;                          // working a..h, a in word 0
    logic [BLK_WORDS-1:0][WORD_W-1:0] w_reg; // w_reg[0] is W[t]

    word_t t1, t2, w_new;
    chain_t v_next;

    always_comb begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[rnd_reg] + w_reg[0];
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
        v_next = {v_reg[6], v_reg[5], v_reg[4], v_reg[3] + t1,
                  v_reg[2], v_reg[1], v_reg[0], t1 + t2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= C_IDLE;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
            h_reg    <= INIT_HASH;
        end else begin
            done_reg <= 1'b0;
            unique case (st_reg)
                C_IDLE: begin
                    if (ctl.reinit) begin
                        h_reg <= INIT_HASH;
                    end
                    if (ctl.start) begin
                        v_reg   <= h_reg;
                        rnd_reg <= '0;
                        for (int i = 0; i < BLK_WORDS; i++) begin
                            w_reg[i] <= block[(BLK_WORDS-1-i)*WORD_W +: WORD_W];
                        end
                        st_reg <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    v_reg <= v_next;
                    for (int i = 0; i < BLK_WORDS-1; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[BLK_WORDS-1] <= w_new;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) begin
                        st_reg <= C_FINAL;
                    end
                end
                C_FINAL: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    done_reg <= 1'b1;
                    st_reg   <= C_IDLE;
                end
                default: st_reg <= C_IDLE;
            endcase
        end
    end

    assign stat.busy = (st_reg != C_IDLE);
    assign stat.done = done_reg;
    assign hash      = h_reg;

    `SHABS_ASSERT_IMPL(a_start_idle, ctl.start, st_reg == C_IDLE)
    `SHABS_ASSERT_NEXT(a_last_round, (st_reg == C_ROUND) && (rnd_reg == 6'd63),
                       st_reg == C_FINAL)
    `SHABS_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg && (st_reg == C_IDLE))

endmodule
